@@ hdl/tfbs_pkg.sv @@
// Shared types, constants and helper functions for the tagged-field blocklist scanner.
`timescale 1ns / 1ps
`default_nettype none

package tfbs_pkg;

  // Default sizes of the blocklist store and the name buffer.
  localparam int LIST_BYTES_DEF = 256;
  localparam int NAME_BYTES_DEF = 64;

  // Length of the "name=" tag that opens a name field.
  localparam int PREFIX_LEN = 5;

  // Image byte counter and limit register.
  localparam int                  COUNT_W         = 27;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0]  MAX_IMAGE_RESET = 27'd67108864;

  // Item commands.
  localparam logic CMD_LIST  = 1'b0;
  localparam logic CMD_IMAGE = 1'b1;

  // Characters with a special meaning.
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_USCORE = 8'h5F;

  // Verdict codes.
  typedef enum logic [1:0] {
    VERDICT_ALLOWED = 2'd0,
    VERDICT_BLOCKED = 2'd1,
    VERDICT_SKIPPED = 2'd2
  } verdict_t;

  // One blocklist store write.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } list_wr_t;

  // Status from the matcher back to the top level.
  typedef struct packed {
    logic done;
    logic hit;
    logic head_nz;
  } match_stat_t;

  // Dash and underscore compare as the same character.
  function automatic logic [7:0] fold_dash(input logic [7:0] c);
    return (c == CHAR_DASH) ? CHAR_USCORE : c;
  endfunction

  // Characters of the "name=" tag.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6E;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6D;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h3D;
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

  // Verdict from the skip condition and the blocked flag.
  function automatic verdict_t verdict_of(input logic skip, input logic blocked);
    verdict_t v;
    if (skip) begin
      v = VERDICT_SKIPPED;
    end else if (blocked) begin
      v = VERDICT_BLOCKED;
    end else begin
      v = VERDICT_ALLOWED;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tfbs_if.sv @@
// Valid/ready channel interfaces for items, verdicts and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

// Input items: blocklist writes and image bytes.
interface tfbs_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] list_index;
  logic [7:0] list_byte;
  logic [7:0] image_byte;
  logic       last_byte;

  modport source (output valid, cmd, list_index, list_byte, image_byte, last_byte,
                  input ready);
  modport sink   (input valid, cmd, list_index, list_byte, image_byte, last_byte,
                  output ready);
endinterface

// Result items: one verdict per image.
interface tfbs_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// Configuration writes of the image length limit.
interface tfbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [26:0] max_image_bytes;

  modport source (output valid, max_image_bytes, input ready);
  modport sink   (input valid, max_image_bytes, output ready);
endinterface

`default_nettype wire

@@ hdl/tagged_field_blocklist_scanner.sv @@
// Top level of the tagged-field blocklist scanner: field tracking, byte count and verdict.
// A blocklist write or an image byte that does not close a name field leaves the scanner idle.
// A byte that closes a "name=" field starts a list walk, a read step and a check step per list
// character, during which no item is taken.
// The verdict sits in an output register from the cycle after the last byte or the walk.
// Reset (synchronous) empties the list, clears the image state and sets the limit to 2^26.
`timescale 1ns / 1ps
`default_nettype none

module tagged_field_blocklist_scanner #(
  parameter int LIST_BYTES = tfbs_pkg::LIST_BYTES_DEF,
  parameter int NAME_BYTES = tfbs_pkg::NAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tfbs_item_if.sink     item_in,
  tfbs_verdict_if.source verdict_out,
  tfbs_cfg_if.sink      cfg
);
  import tfbs_pkg::*;

  localparam int PosMax = NAME_BYTES + PREFIX_LEN + 1;
  localparam int PosW   = $clog2(PosMax + 1);
  localparam int NameAw = $clog2(NAME_BYTES);
  localparam int LenW   = $clog2(NAME_BYTES + 1);
  localparam logic [PosW-1:0] PosMaxV    = PosW'(PosMax);
  localparam logic [PosW-1:0] PrefixLenV = PosW'(PREFIX_LEN);
  localparam logic [PosW-1:0] NameBytesV = PosW'(NAME_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t              state;
  logic [PosW-1:0]     pos;
  logic                prefix_ok;
  logic                too_long;
  logic                found;
  logic [COUNT_W-1:0]  byte_count;
  logic [COUNT_W-1:0]  max_bytes;
  logic                last_pend;
  logic                skip_pend;
  logic                out_vld;
  verdict_t            out_verdict;

  logic                acc;
  logic                img;
  logic [7:0]          b;
  logic [COUNT_W-1:0]  count_inc;
  logic                skip_now;
  logic [PosW-1:0]     name_idx;
  logic                walk_go;
  logic                name_we;
  logic                start;
  list_wr_t            list_wr;
  match_stat_t         mstat;

  // Handshakes: one item at a time, and only when the verdict register can take a result.
  assign item_in.ready     = (state == S_IDLE) && (!out_vld || verdict_out.ready);
  assign acc               = item_in.valid && item_in.ready;
  assign cfg.ready         = 1'b1;
  assign verdict_out.valid = out_vld;
  assign verdict_out.verdict = out_verdict;

  // Decode of the current image byte.
  assign img       = item_in.cmd == CMD_IMAGE;
  assign b         = item_in.image_byte;
  assign count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;
  assign skip_now  = !mstat.head_nz || (count_inc > max_bytes);
  assign name_idx  = pos - PrefixLenV;
  assign walk_go   = (b == CHAR_NUL) && (pos > PrefixLenV) && prefix_ok && !too_long;

  // Requests to the matcher.
  assign name_we = acc && img && (b != CHAR_NUL) && (pos >= PrefixLenV)
                   && (name_idx < NameBytesV);
  assign start   = acc && img && walk_go;
  assign list_wr = '{en: acc && !img, addr: item_in.list_index, data: item_in.list_byte};

  tfbs_matcher #(
    .LIST_BYTES (LIST_BYTES),
    .NAME_BYTES (NAME_BYTES)
  ) u_matcher (
    .clk        (clk),
    .rst        (rst),
    .list_wr    (list_wr),
    .name_we    (name_we),
    .name_waddr (name_idx[NameAw-1:0]),
    .name_wdata (b),
    .start      (start),
    .name_len   (name_idx[LenW-1:0]),
    .stat       (mstat)
  );

  // Field tracking, byte count, verdict register and the limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      prefix_ok  <= 1'b1;
      too_long   <= 1'b0;
      found      <= 1'b0;
      byte_count <= '0;
      max_bytes  <= MAX_IMAGE_RESET;
      last_pend  <= 1'b0;
      skip_pend  <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_bytes <= cfg.max_image_bytes;
      end
      if (verdict_out.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && img) begin
            // Advance the field state by one byte.
            if (b == CHAR_NUL) begin
              pos       <= '0;
              prefix_ok <= 1'b1;
              too_long  <= 1'b0;
            end else begin
              if (pos < PrefixLenV) begin
                if (b != prefix_char(pos[2:0])) begin
                  prefix_ok <= 1'b0;
                end
              end else if (name_idx >= NameBytesV) begin
                too_long <= 1'b1;
              end
              if (pos != PosMaxV) begin
                pos <= pos + 1'b1;
              end
            end
            // The last byte closes the image whatever the verdict.
            if (item_in.last_byte) begin
              pos        <= '0;
              prefix_ok  <= 1'b1;
              too_long   <= 1'b0;
              byte_count <= '0;
              if (walk_go) begin
                state     <= S_WALK;
                last_pend <= 1'b1;
                skip_pend <= skip_now;
              end else begin
                out_vld     <= 1'b1;
                out_verdict <= verdict_of(skip_now, found);
                found       <= 1'b0;
              end
            end else begin
              byte_count <= count_inc;
              if (walk_go) begin
                state     <= S_WALK;
                last_pend <= 1'b0;
              end
            end
          end
        end
        S_WALK: begin
          if (mstat.done) begin
            state <= S_IDLE;
            if (last_pend) begin
              out_vld     <= 1'b1;
              out_verdict <= verdict_of(skip_pend, found || mstat.hit);
              found       <= 1'b0;
            end else begin
              found <= found || mstat.hit;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/tfbs_matcher.sv @@
// Blocklist store, name buffer and the sequencer that walks the list with one compare unit.
`timescale 1ns / 1ps
`default_nettype none

module tfbs_matcher #(
  parameter int LIST_BYTES = tfbs_pkg::LIST_BYTES_DEF,
  parameter int NAME_BYTES = tfbs_pkg::NAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tfbs_pkg::list_wr_t                list_wr,
  input  logic                              name_we,
  input  logic [$clog2(NAME_BYTES)-1:0]     name_waddr,
  input  logic [7:0]                        name_wdata,
  input  logic                              start,
  input  logic [$clog2(NAME_BYTES+1)-1:0]   name_len,
  output tfbs_pkg::match_stat_t             stat
);
  import tfbs_pkg::*;

  // Only the first 256 places can ever be written; the rest always read as zero.
  localparam int StoreDepth = (LIST_BYTES < 256) ? LIST_BYTES : 256;
  localparam int ListAw     = $clog2(StoreDepth);
  localparam int IdxW       = $clog2(StoreDepth + 1);
  localparam int NameAw     = $clog2(NAME_BYTES);
  localparam int LenW       = $clog2(NAME_BYTES + 1);
  localparam logic [IdxW-1:0] EndIdx = IdxW'(StoreDepth);

  typedef enum logic [2:0] {
    M_IDLE  = 3'b001,
    M_READ  = 3'b010,
    M_CHECK = 3'b100
  } mstate_t;

  mstate_t                state;
  logic [IdxW-1:0]        idx;
  logic [LenW-1:0]        k;
  logic [LenW-1:0]        len_r;
  logic                   mis;
  logic                   done_q;
  logic                   hit_q;
  logic                   head_nz;
  logic [StoreDepth-1:0]  list_vld;

  logic [7:0]             list_mem [StoreDepth];
  logic [7:0]             name_mem [NAME_BYTES];
  logic [7:0]             list_q;
  logic                   vld_q;
  logic [7:0]             name_q;

  logic                   addr_ok;
  logic [ListAw-1:0]      list_waddr;
  logic                   list_rd;
  logic                   name_rd;
  logic [7:0]             c;
  logic                   sep;
  logic                   entry_hit;
  logic                   char_ok;

  // Write address decode for the blocklist store.
  assign addr_ok    = int'(list_wr.addr) < StoreDepth;
  assign list_waddr = list_wr.addr[ListAw-1:0];

  // Reads are issued in the read step and used in the check step.
  assign list_rd = (state == M_READ) && (idx != EndIdx);
  assign name_rd = (state == M_READ) && (k < len_r);

  // Shared compare unit: current list character against the name character.
  assign c         = ((idx == EndIdx) || !vld_q) ? CHAR_NUL : list_q;
  assign sep       = (c == CHAR_NUL) || (c == CHAR_COMMA);
  assign entry_hit = (k == len_r) && !mis;
  assign char_ok   = fold_dash(c) == fold_dash(name_q);

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (list_wr.en && addr_ok) begin
      list_mem[list_waddr] <= list_wr.data;
    end
    if (list_rd) begin
      list_q <= list_mem[idx[ListAw-1:0]];
      vld_q  <= list_vld[idx[ListAw-1:0]];
    end
    if (name_we) begin
      name_mem[name_waddr] <= name_wdata;
    end
    if (name_rd) begin
      name_q <= name_mem[k[NameAw-1:0]];
    end
  end

  // Store valid bits and the empty-list flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      list_vld <= '0;
      head_nz  <= 1'b0;
    end else if (list_wr.en && addr_ok) begin
      list_vld[list_waddr] <= 1'b1;
      if (list_waddr == '0) begin
        head_nz <= list_wr.data != CHAR_NUL;
      end
    end
  end

  // List walk sequencer: one list character per read and check pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= M_IDLE;
      idx    <= '0;
      k      <= '0;
      len_r  <= '0;
      mis    <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            len_r <= name_len;
            idx   <= '0;
            k     <= '0;
            mis   <= 1'b0;
            state <= M_READ;
          end
        end
        M_READ: begin
          state <= M_CHECK;
        end
        M_CHECK: begin
          if (sep) begin
            if (entry_hit) begin
              done_q <= 1'b1;
              hit_q  <= 1'b1;
              state  <= M_IDLE;
            end else if (c == CHAR_NUL) begin
              done_q <= 1'b1;
              hit_q  <= 1'b0;
              state  <= M_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              k     <= '0;
              mis   <= 1'b0;
              state <= M_READ;
            end
          end else begin
            // An entry longer than the name can never match.
            if (k < len_r) begin
              if (!char_ok) begin
                mis <= 1'b1;
              end
              k <= k + 1'b1;
            end else begin
              mis <= 1'b1;
            end
            idx   <= idx + 1'b1;
            state <= M_READ;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign stat = '{done: done_q, hit: hit_q, head_nz: head_nz};

endmodule

`default_nettype wire

@@ hdl/tfbs_checker.sv @@
// Port-level checks of the scanner and the bind that attaches them to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tfbs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_cmd,
  input wire logic [7:0] in_image_byte,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_verdict
);
  import tfbs_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // No beat is taken while a verdict waits and is not being taken.
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while verdict register is full");

  // A blocklist write never produces a verdict.
  a_list_write_silent: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_cmd == CMD_LIST) && !out_valid) |=> !out_valid)
    else $error("verdict after a blocklist write");

  // A last byte that closes no field gives its verdict in the next cycle.
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_cmd == CMD_IMAGE) && in_last && (in_image_byte != CHAR_NUL))
      |=> out_valid)
    else $error("no verdict after last image byte");

  // A stalled verdict holds.
  a_verdict_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_verdict)))
    else $error("stalled verdict changed or dropped");

endmodule

bind tagged_field_blocklist_scanner tfbs_checker u_tfbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item_in.valid),
  .in_ready      (item_in.ready),
  .in_cmd        (item_in.cmd),
  .in_image_byte (item_in.image_byte),
  .in_last       (item_in.last_byte),
  .out_valid     (verdict_out.valid),
  .out_ready     (verdict_out.ready),
  .out_verdict   (verdict_out.verdict)
);

`default_nettype wire
